### rtl/sem_tbl_pkg.sv
// ----------------------------------------------------------------------------
// Semaphore table package
// Shared widths, request and status codes, and controller states.
// ----------------------------------------------------------------------------
package sem_tbl_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int NUM_TASKS_DEF = 16;

    localparam int IDX_W   = 8;
    localparam int INIT_W  = 6;
    localparam int TASK_W  = 4;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 3;
    localparam int SLOT_OUT_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_CLOSE  = 2'd1,
        REQ_WAIT   = 2'd2,
        REQ_SIGNAL = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_LOOKUP = 2'd2,
        S_FINISH = 2'd3
    } state_t;

endpackage

### rtl/sem_tbl_ram.sv
// ----------------------------------------------------------------------------
// Semaphore table RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sem_tbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/counting_semaphore_table_top.sv
// ----------------------------------------------------------------------------
// Counting semaphore table
// A taken request goes through the lookup state (slot RAM read-modify-write,
// wait-queue RAM access) and the finish state, which loads the result when the
// output has room; a new request is taken only when idle or as that result
// loads. Reset: all slots become free and the wait-queue RAM is swept to zero,
// one entry a cycle, 2^(clog2(NUM_SLOTS)+clog2(NUM_TASKS)) entries (256 by default).
// ----------------------------------------------------------------------------
module counting_semaphore_table_top #(
    parameter int NUM_SLOTS = sem_tbl_pkg::NUM_SLOTS_DEF,
    parameter int NUM_TASKS = sem_tbl_pkg::NUM_TASKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sem_index[7:0], initial_value[13:8], task_id[17:14]
    input  logic [sem_tbl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [sem_tbl_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[2:0], new_slot[6:3], caller_blocks[7], wake_valid[8], wake_task[12:9]
    output logic [sem_tbl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_SPAN = 1 << SW;
    localparam int PW        = $clog2(NUM_TASKS);
    localparam int QAW       = SW + PW;
    localparam int CW        = sem_tbl_pkg::COUNT_W;
    localparam int WORD_W    = CW + 2 * PW;

    localparam logic signed [CW-1:0] TASK_LIMIT = CW'(NUM_TASKS);
    localparam logic signed [CW-1:0] NEG_LIMIT  = CW'(-NUM_TASKS);
    localparam logic signed [CW-1:0] COUNT_ONE  = CW'(1);
    localparam logic [PW-1:0]        PTR_LAST   = PW'(NUM_TASKS - 1);

    sem_tbl_pkg::state_t state_reg, state_next;

    logic [SLOT_SPAN-1:0] in_use_reg, in_use_next;
    logic [QAW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    sem_tbl_pkg::req_t             kind_reg;
    logic [sem_tbl_pkg::IDX_W-1:0]  idx_reg;
    logic [sem_tbl_pkg::INIT_W-1:0] init_reg;
    logic [sem_tbl_pkg::TASK_W-1:0] task_reg;

    sem_tbl_pkg::status_t              status_reg, status_next;
    logic [sem_tbl_pkg::SLOT_OUT_W-1:0] new_slot_reg, new_slot_next;
    logic                               blocks_reg, blocks_next;
    logic                               wake_reg, wake_next;
    logic [sem_tbl_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                 accept;
    logic                 out_room;
    logic                 load_out;

    logic                 slot_we;
    logic [SW-1:0]        slot_waddr;
    logic [WORD_W-1:0]    slot_wdata;
    logic [WORD_W-1:0]    slot_rdata;

    logic                 q_we;
    logic [QAW-1:0]       q_waddr;
    logic [sem_tbl_pkg::TASK_W-1:0] q_wdata;
    logic                 q_re;
    logic [QAW-1:0]       q_raddr;
    logic [sem_tbl_pkg::TASK_W-1:0] q_rdata;

    logic [SW-1:0]          idx_t;
    logic signed [CW-1:0]   count_rd;
    logic [PW-1:0]          head_rd;
    logic [PW-1:0]          tail_rd;
    logic signed [CW-1:0]   count_new;
    logic signed [CW-1:0]   init_ext;
    logic                   free_found;
    logic [SW-1:0]          free_slot;
    logic [sem_tbl_pkg::IDX_W-1:0] free_slot_wide;
    logic [sem_tbl_pkg::TASK_W-1:0] wake_task;

    assign out_room      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == sem_tbl_pkg::S_IDLE) ||
                           ((state_reg == sem_tbl_pkg::S_FINISH) && out_room);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign idx_t    = idx_reg[SW-1:0];
    assign count_rd = slot_rdata[WORD_W-1 -: CW];
    assign head_rd  = slot_rdata[2*PW-1 -: PW];
    assign tail_rd  = slot_rdata[PW-1:0];
    assign init_ext = {{(CW - sem_tbl_pkg::INIT_W){init_reg[sem_tbl_pkg::INIT_W-1]}},
                       init_reg};

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    assign free_slot_wide = sem_tbl_pkg::IDX_W'(free_slot);

    sem_tbl_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOT_SPAN)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .re   (accept),
        .raddr(s_axis_tdata[SW-1:0]),
        .rdata(slot_rdata)
    );

    sem_tbl_ram #(
        .WIDTH(sem_tbl_pkg::TASK_W),
        .DEPTH(1 << QAW)
    ) u_queue_ram (
        .clk  (clk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .re   (q_re),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        clr_cnt_next   = clr_cnt_reg;
        status_next    = status_reg;
        new_slot_next  = new_slot_reg;
        blocks_next    = blocks_reg;
        wake_next      = wake_reg;
        slot_we        = 1'b0;
        slot_waddr     = idx_t;
        slot_wdata     = slot_rdata;
        q_we           = 1'b0;
        q_waddr        = {idx_t, tail_rd};
        q_wdata        = task_reg;
        q_re           = 1'b0;
        q_raddr        = {idx_t, head_rd};
        count_new      = count_rd;
        load_out       = 1'b0;

        case (state_reg)
            sem_tbl_pkg::S_CLEAR:
            begin
                q_we         = 1'b1;
                q_waddr      = clr_cnt_reg;
                q_wdata      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = sem_tbl_pkg::S_IDLE;
                end
            end

            sem_tbl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sem_tbl_pkg::S_LOOKUP;
                end
            end

            sem_tbl_pkg::S_LOOKUP:
            begin
                status_next   = sem_tbl_pkg::ST_OK;
                new_slot_next = '0;
                blocks_next   = 1'b0;
                wake_next     = 1'b0;
                state_next    = sem_tbl_pkg::S_FINISH;
                if (kind_reg == sem_tbl_pkg::REQ_CREATE)
                begin
                    if (init_ext >= TASK_LIMIT)
                    begin
                        status_next = sem_tbl_pkg::ST_TOO_LARGE;
                    end
                    else if (!free_found)
                    begin
                        status_next = sem_tbl_pkg::ST_NO_SLOT;
                    end
                    else
                    begin
                        in_use_next[free_slot] = 1'b1;
                        slot_we       = 1'b1;
                        slot_waddr    = free_slot;
                        slot_wdata    = {init_ext, {PW{1'b0}}, {PW{1'b0}}};
                        new_slot_next = free_slot_wide[sem_tbl_pkg::SLOT_OUT_W-1:0];
                    end
                end
                else if ((idx_reg >= sem_tbl_pkg::IDX_W'(NUM_SLOTS)) || !in_use_reg[idx_t])
                begin
                    status_next = sem_tbl_pkg::ST_IGNORED;
                end
                else if (kind_reg == sem_tbl_pkg::REQ_CLOSE)
                begin
                    in_use_next[idx_t] = 1'b0;
                end
                else if (kind_reg == sem_tbl_pkg::REQ_WAIT)
                begin
                    if (count_rd <= NEG_LIMIT)
                    begin
                        status_next = sem_tbl_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        count_new = count_rd - COUNT_ONE;
                        slot_we   = 1'b1;
                        if (count_new < 0)
                        begin
                            q_we        = 1'b1;
                            blocks_next = 1'b1;
                            slot_wdata  = {count_new, head_rd,
                                           (tail_rd == PTR_LAST) ? PW'(0) : tail_rd + 1'b1};
                        end
                        else
                        begin
                            slot_wdata = {count_new, head_rd, tail_rd};
                        end
                    end
                end
                else
                begin
                    if (count_rd < sem_tbl_pkg::COUNT_MAX)
                    begin
                        count_new = count_rd + COUNT_ONE;
                        slot_we   = 1'b1;
                        if (count_new <= 0)
                        begin
                            q_re       = 1'b1;
                            wake_next  = 1'b1;
                            slot_wdata = {count_new,
                                          (head_rd == PTR_LAST) ? PW'(0) : head_rd + 1'b1,
                                          tail_rd};
                        end
                        else
                        begin
                            slot_wdata = {count_new, head_rd, tail_rd};
                        end
                    end
                end
            end

            sem_tbl_pkg::S_FINISH:
            begin
                if (out_room)
                begin
                    load_out = 1'b1;
                    if (accept)
                    begin
                        state_next = sem_tbl_pkg::S_LOOKUP;
                    end
                    else
                    begin
                        state_next = sem_tbl_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sem_tbl_pkg::S_IDLE;
            end
        endcase
    end

    assign wake_task = wake_reg ? q_rdata : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, wake_task, wake_reg, blocks_reg,
                              new_slot_reg, status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem_tbl_pkg::S_CLEAR;
            in_use_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= sem_tbl_pkg::req_t'(s_axis_tuser[1:0]);
            idx_reg  <= s_axis_tdata[7:0];
            init_reg <= s_axis_tdata[13:8];
            task_reg <= s_axis_tdata[17:14];
        end
        status_reg   <= status_next;
        new_slot_reg <= new_slot_next;
        blocks_reg   <= blocks_next;
        wake_reg     <= wake_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
